>>> sv/descriptor_table_allocator_core_defines.svh
`ifndef DESCRIPTOR_TABLE_ALLOCATOR_CORE_DEFINES_SVH
`define DESCRIPTOR_TABLE_ALLOCATOR_CORE_DEFINES_SVH

// property that must never hold on a clock edge outside reset
`define DTA_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define DTA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/dta_pkg.sv
`timescale 1ns / 1ps

package dta_pkg;

  localparam int DTA_TABLE_DEPTH = 64;
  localparam int HANDLE_W        = 16;
  localparam int OFFSET_W        = 64;
  localparam int RIDX_W          = 6;
  localparam int CFG_DATA_W      = 16;
  localparam int CFG_IDX_W       = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FIRST_ALLOC = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NULL_HANDLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_HANDLE = 2'd2;

  localparam logic [RIDX_W-1:0]   FIRST_ALLOC_RST  = 6'd1;
  localparam logic [HANDLE_W-1:0] NULL_HANDLE_RST  = 16'h0000;
  localparam logic [HANDLE_W-1:0] ERROR_HANDLE_RST = 16'hffff;

  typedef enum logic [2:0] {
    ACT_ALLOC   = 3'd0,
    ACT_BIND    = 3'd1,
    ACT_FREE    = 3'd2,
    ACT_LOOKUP  = 3'd3,
    ACT_SET_OFF = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_INVALID = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SEQ_CLEAR,
    SEQ_IDLE,
    SEQ_SCAN,
    SEQ_EVAL
  } seq_state_t;

  typedef struct packed {
    logic [RIDX_W-1:0]   first_alloc_index;
    logic [HANDLE_W-1:0] null_handle;
    logic [HANDLE_W-1:0] error_handle;
  } cfg_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [OFFSET_W-1:0] offset;
  } entry_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [RIDX_W-1:0]   index;
    logic [HANDLE_W-1:0] handle;
    logic [OFFSET_W-1:0] offset;
    logic                rel_valid;
    logic [HANDLE_W-1:0] rel_handle;
  } res_t;

endpackage

>>> sv/dta_ram.sv
`timescale 1ns / 1ps

module dta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/dta_cfg.sv
`timescale 1ns / 1ps

module dta_cfg import dta_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_alloc_index <= FIRST_ALLOC_RST;
      cfg.null_handle       <= NULL_HANDLE_RST;
      cfg.error_handle      <= ERROR_HANDLE_RST;
    end else if (cfg_we) begin
      // writes past the register list are dropped
      unique case (cfg_index)
        REG_FIRST_ALLOC:  cfg.first_alloc_index <= cfg_data[RIDX_W-1:0];
        REG_NULL_HANDLE:  cfg.null_handle       <= cfg_data[HANDLE_W-1:0];
        REG_ERROR_HANDLE: cfg.error_handle      <= cfg_data[HANDLE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> sv/dta_seq.sv
`timescale 1ns / 1ps

`include "descriptor_table_allocator_core_defines.svh"

module dta_seq import dta_pkg::*; #(
  parameter int TABLE_DEPTH = DTA_TABLE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  cfg_t                           cfg,
  input  logic                           start,
  input  logic [2:0]                     action,
  input  logic [7:0]                     slot_index,
  input  logic [HANDLE_W-1:0]            handle,
  input  logic [OFFSET_W-1:0]            new_offset,
  output logic                           busy,
  output logic                           done,
  output res_t                           res,
  output logic                           ram_we,
  output logic [$clog2(TABLE_DEPTH)-1:0] ram_waddr,
  output entry_t                         ram_wdata,
  output logic                           ram_re,
  output logic [$clog2(TABLE_DEPTH)-1:0] ram_raddr,
  input  entry_t                         ram_rdata
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic [AW-1:0] LAST = AW'(TABLE_DEPTH - 1);

  seq_state_t state, state_next;
  logic [AW-1:0] ptr, ptr_next;
  logic [2:0] act;
  logic [HANDLE_W-1:0] hnd;
  logic [OFFSET_W-1:0] noff;
  res_t res_next;
  logic emit;

  logic acc, first_ok, idx_ok, act_known, old_empty;
  logic [AW-1:0] start_addr;

  assign acc       = start && (state == SEQ_IDLE);
  assign first_ok  = 32'(cfg.first_alloc_index) < TABLE_DEPTH;
  assign idx_ok    = 32'(slot_index) < TABLE_DEPTH;
  assign act_known = action <= ACT_SET_OFF;
  assign start_addr = (action == ACT_ALLOC) ? AW'(cfg.first_alloc_index) : AW'(slot_index);
  assign old_empty = ram_rdata.handle == cfg.null_handle;
  assign busy      = state != SEQ_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_CLEAR;
      ptr   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      ptr   <= ptr_next;
      done  <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      act  <= action;
      hnd  <= handle;
      noff <= new_offset;
    end
    if (emit) begin
      res <= res_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      SEQ_CLEAR: begin
        if (ptr == LAST) state_next = SEQ_IDLE;
      end
      SEQ_IDLE: begin
        if (acc) begin
          if (action == ACT_ALLOC) begin
            if (first_ok) state_next = SEQ_SCAN;
          end else if (act_known && idx_ok) begin
            state_next = SEQ_EVAL;
          end
        end
      end
      SEQ_SCAN: begin
        if (old_empty || ptr == LAST) state_next = SEQ_IDLE;
      end
      SEQ_EVAL: state_next = SEQ_IDLE;
      default: state_next = SEQ_IDLE;
    endcase
  end

  // memory access and result word
  always_comb begin
    ptr_next  = ptr;
    ram_re    = 1'b0;
    ram_raddr = start_addr;
    ram_we    = 1'b0;
    ram_waddr = ptr;
    ram_wdata = '0;
    emit      = 1'b0;
    res_next  = '0;
    unique case (state)
      SEQ_CLEAR: begin
        ram_we   = 1'b1;
        ptr_next = ptr + 1'b1;
      end
      SEQ_IDLE: begin
        if (acc) begin
          ptr_next = start_addr;
          if (action == ACT_ALLOC) begin
            if (first_ok) begin
              ram_re = 1'b1;
            end else begin
              emit = 1'b1;
              res_next.status = ST_FULL;
            end
          end else if (act_known && idx_ok) begin
            ram_re = 1'b1;
          end else begin
            emit = 1'b1;
            res_next.status = ST_INVALID;
            if (action == ACT_LOOKUP) res_next.handle = cfg.error_handle;
          end
        end
      end
      SEQ_SCAN: begin
        if (old_empty) begin
          ram_we           = 1'b1;
          ram_wdata.handle = hnd;
          emit             = 1'b1;
          res_next.status  = ST_OK;
          res_next.index   = RIDX_W'(ptr);
          res_next.handle  = hnd;
        end else if (ptr == LAST) begin
          emit            = 1'b1;
          res_next.status = ST_FULL;
        end else begin
          ptr_next  = ptr + 1'b1;
          ram_re    = 1'b1;
          ram_raddr = ptr + 1'b1;
        end
      end
      SEQ_EVAL: begin
        emit = 1'b1;
        if (act == ACT_BIND) begin
          if (hnd == cfg.null_handle || hnd == cfg.error_handle) begin
            res_next.status = ST_INVALID;
          end else begin
            ram_we           = 1'b1;
            ram_wdata.handle = hnd;
            res_next.status  = ST_OK;
            res_next.handle  = hnd;
            if (!old_empty && ram_rdata.handle != hnd) begin
              res_next.rel_valid  = 1'b1;
              res_next.rel_handle = ram_rdata.handle;
            end
          end
        end else if (old_empty) begin
          res_next.status = ST_EMPTY;
          if (act == ACT_LOOKUP) res_next.handle = cfg.error_handle;
        end else begin
          res_next.status = ST_OK;
          res_next.handle = ram_rdata.handle;
          res_next.offset = ram_rdata.offset;
          if (act == ACT_FREE) begin
            ram_we              = 1'b1;
            ram_wdata.handle    = cfg.null_handle;
            res_next.rel_valid  = 1'b1;
            res_next.rel_handle = ram_rdata.handle;
          end else if (act == ACT_SET_OFF) begin
            ram_we           = 1'b1;
            ram_wdata.handle = ram_rdata.handle;
            ram_wdata.offset = noff;
            res_next.offset  = noff;
          end
        end
      end
      default: ;
    endcase
  end

  `DTA_ASSERT_NEVER(a_no_write_idle, ram_we && state == SEQ_IDLE, "table write while idle")
  `DTA_ASSERT_NEVER(a_no_done_clear, done && state == SEQ_CLEAR, "result during clearing pass")
  `DTA_ASSERT_NEXT(a_read_then_busy, acc && ram_re, busy, "read issued but sequencer idle")
  `DTA_ASSERT_NEVER(a_rel_only_ok, emit && res_next.rel_valid && res_next.status != ST_OK,
                    "release on a failed action")

endmodule

>>> sv/descriptor_table_allocator_core.sv
`timescale 1ns / 1ps

// Descriptor table: start is taken when busy is low; every command gives exactly one
// result word, shown for one cycle with done high, and the receiver cannot stall it.
// Bind, free, lookup and set offset read one entry in the table memory, then bind, free
// and set offset may write it back; an out-of-range index or unknown action is answered
// without a table read. Allocate walks the table memory one entry a cycle from
// first_alloc_index and stops at the first free slot (or at the end of the table).
// After reset the table is cleared one slot a cycle with busy high; configuration writes
// are taken at any time but belong in idle periods.
module descriptor_table_allocator_core import dta_pkg::*; #(
  parameter int TABLE_DEPTH = DTA_TABLE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  start,
  output logic                  busy,
  input  logic [2:0]            action,
  input  logic [7:0]            slot_index,
  input  logic [HANDLE_W-1:0]   handle,
  input  logic [OFFSET_W-1:0]   new_offset,
  output logic                  done,
  output logic [1:0]            status,
  output logic [RIDX_W-1:0]     result_index,
  output logic [HANDLE_W-1:0]   result_handle,
  output logic [OFFSET_W-1:0]   result_offset,
  output logic                  release_valid,
  output logic [HANDLE_W-1:0]   release_handle
);

  localparam int AW = $clog2(TABLE_DEPTH);

  cfg_t cfg;
  res_t res;
  logic ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  entry_t ram_wdata, ram_rdata;

  dta_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dta_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  dta_seq #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .start      (start),
    .action     (action),
    .slot_index (slot_index),
    .handle     (handle),
    .new_offset (new_offset),
    .busy       (busy),
    .done       (done),
    .res        (res),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

  assign status         = res.status;
  assign result_index   = res.index;
  assign result_handle  = res.handle;
  assign result_offset  = res.offset;
  assign release_valid  = res.rel_valid;
  assign release_handle = res.rel_handle;

endmodule

>>> verif/tb_descriptor_table_allocator_core.sv
`timescale 1ns / 1ps

module tb_descriptor_table_allocator_core;
  import dta_pkg::*;

  localparam int DEPTH = DTA_TABLE_DEPTH;
  // covers the longest allocate scan, with margin
  localparam int SETTLE_CYCLES = DEPTH + 6;
  localparam logic [2:0] ACT_BAD_FIRST = 3'd5;
  localparam logic [2:0] ACT_BAD_LAST = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [2:0]            action = '0;
  logic [7:0]            slot_index = '0;
  logic [HANDLE_W-1:0]   handle = '0;
  logic [OFFSET_W-1:0]   new_offset = '0;
  logic                  done;
  logic [1:0]            status;
  logic [RIDX_W-1:0]     result_index;
  logic [HANDLE_W-1:0]   result_handle;
  logic [OFFSET_W-1:0]   result_offset;
  logic                  release_valid;
  logic [HANDLE_W-1:0]   release_handle;

  // mirror of the descriptor table and its registers
  logic [HANDLE_W-1:0] mirror_handle [DEPTH];
  logic [OFFSET_W-1:0] mirror_offset [DEPTH];
  logic [RIDX_W-1:0]   cfg_first;
  logic [HANDLE_W-1:0] cfg_null;
  logic [HANDLE_W-1:0] cfg_error;

  res_t pending_results[$];
  int   mismatch_count = 0;
  int   burst_left = 0;

  descriptor_table_allocator_core DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .start          (start),
    .busy           (busy),
    .action         (action),
    .slot_index     (slot_index),
    .handle         (handle),
    .new_offset     (new_offset),
    .done           (done),
    .status         (status),
    .result_index   (result_index),
    .result_handle  (result_handle),
    .result_offset  (result_offset),
    .release_valid  (release_valid),
    .release_handle (release_handle)
  );

  always #5 clk = ~clk;

  function automatic res_t predict_table_op(input logic [2:0] act, input logic [7:0] idx,
                                            input logic [HANDLE_W-1:0] h,
                                            input logic [OFFSET_W-1:0] noff);
    res_t                r;
    int                  i;
    logic                found;
    logic [RIDX_W-1:0]   s;
    logic [HANDLE_W-1:0] old;
    r = '0;
    if (act == ACT_ALLOC) begin
      found = 1'b0;
      for (i = cfg_first; i < DEPTH; i++) begin
        if (!found && mirror_handle[i] == cfg_null) begin
          found = 1'b1;
          mirror_handle[i] = h;
          mirror_offset[i] = '0;
          r.status = ST_OK;
          r.index = RIDX_W'(i);
          r.handle = h;
        end
      end
      if (!found) r.status = ST_FULL;
      return r;
    end
    if (act > ACT_SET_OFF || idx >= DEPTH) begin
      r.status = ST_INVALID;
      if (act == ACT_LOOKUP) r.handle = cfg_error;
      return r;
    end
    s = idx[RIDX_W-1:0];
    old = mirror_handle[s];
    if (act == ACT_BIND) begin
      if (h == cfg_null || h == cfg_error) begin
        r.status = ST_INVALID;
        return r;
      end
      r.status = ST_OK;
      r.handle = h;
      r.rel_valid = (old != cfg_null) && (old != h);
      r.rel_handle = r.rel_valid ? old : '0;
      mirror_handle[s] = h;
      mirror_offset[s] = '0;
      return r;
    end
    if (old == cfg_null) begin
      r.status = ST_EMPTY;
      if (act == ACT_LOOKUP) r.handle = cfg_error;
      return r;
    end
    r.status = ST_OK;
    r.handle = old;
    if (act == ACT_FREE) begin
      r.offset = mirror_offset[s];
      r.rel_valid = 1'b1;
      r.rel_handle = old;
      mirror_handle[s] = cfg_null;
      mirror_offset[s] = '0;
      return r;
    end
    if (act == ACT_SET_OFF) mirror_offset[s] = noff;
    r.offset = mirror_offset[s];
    return r;
  endfunction

  // check the result word first, then log any command taken on the same edge
  always @(posedge clk) begin
    res_t want;
    if (!rst) begin
      if (done) begin
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unexpected result word st=%0d h=%h", $time, status, result_handle);
        end else begin
          want = pending_results.pop_front();
          if (status !== want.status || result_index !== want.index ||
              result_handle !== want.handle || result_offset !== want.offset ||
              release_valid !== want.rel_valid || release_handle !== want.rel_handle) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("%0t: mismatch expected st=%0d idx=%0d h=%h off=%h rel=%b/%h",
                       $time, want.status, want.index, want.handle, want.offset,
                       want.rel_valid, want.rel_handle);
              $display("%0t:          got      st=%0d idx=%0d h=%h off=%h rel=%b/%h",
                       $time, status, result_index, result_handle, result_offset,
                       release_valid, release_handle);
            end
          end
        end
      end
      if (start && !busy)
        pending_results.push_back(predict_table_op(action, slot_index, handle, new_offset));
    end
  end

  // start is left high; the pacing or drain task lowers it
  task automatic send_cmd(input logic [2:0] act, input logic [7:0] idx,
                          input logic [HANDLE_W-1:0] h, input logic [OFFSET_W-1:0] noff);
    start <= 1'b1;
    action <= act;
    slot_index <= idx;
    handle <= h;
    new_offset <= noff;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 6);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending_results.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] first_v,
                            input logic [CFG_DATA_W-1:0] null_v,
                            input logic [CFG_DATA_W-1:0] err_v);
    cfg_we <= 1'b1;
    cfg_index <= REG_FIRST_ALLOC;
    cfg_data <= first_v;
    @(posedge clk);
    cfg_index <= REG_NULL_HANDLE;
    cfg_data <= null_v;
    @(posedge clk);
    cfg_index <= REG_ERROR_HANDLE;
    cfg_data <= err_v;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_first = first_v[RIDX_W-1:0];
    cfg_null = null_v;
    cfg_error = err_v;
  endtask

  task automatic test_directed_cases();
    send_cmd(ACT_LOOKUP, 8'd0, 16'h0000, '0);
    send_cmd(ACT_ALLOC, 8'd0, 16'h1234, '0);
    // error handle and null handle are both accepted by allocate
    send_cmd(ACT_ALLOC, 8'hff, ERROR_HANDLE_RST, '1);
    send_cmd(ACT_ALLOC, 8'd0, NULL_HANDLE_RST, '0);
    send_cmd(ACT_ALLOC, 8'd0, 16'habcd, '0);
    send_cmd(ACT_SET_OFF, 8'd1, 16'h0000, '1);
    send_cmd(ACT_LOOKUP, 8'd1, 16'h0000, '0);
    send_cmd(ACT_SET_OFF, 8'd4, 16'h0000, 64'h0123_4567_89ab_cdef);
    send_cmd(ACT_BIND, 8'd1, 16'h5555, '0);
    send_cmd(ACT_BIND, 8'd1, 16'h5555, '1);
    send_cmd(ACT_BIND, 8'd0, NULL_HANDLE_RST, '0);
    send_cmd(ACT_BIND, 8'd0, ERROR_HANDLE_RST, '0);
    send_cmd(ACT_BIND, 8'd63, 16'h8000, '0);
    send_cmd(ACT_SET_OFF, 8'd63, 16'hffff, 64'h8000_0000_0000_0001);
    send_cmd(ACT_FREE, 8'd63, 16'h0000, '0);
    send_cmd(ACT_FREE, 8'd63, 16'h0000, '0);
    send_cmd(ACT_LOOKUP, 8'd64, 16'h0000, '0);
    send_cmd(ACT_FREE, 8'd255, 16'h0000, '0);
    send_cmd(ACT_BIND, 8'd128, 16'h7777, '0);
    send_cmd(ACT_SET_OFF, 8'd200, 16'h0000, '1);
    for (int a = ACT_BAD_FIRST; a <= ACT_BAD_LAST; a++)
      send_cmd(3'(a), 8'd1, 16'hffff, '1);
    send_cmd(ACT_ALLOC, 8'd0, 16'h0001, '0);
    send_cmd(ACT_LOOKUP, 8'd2, 16'h0000, '0);
    wait_idle();
  endtask

  task automatic test_table_full();
    set_config(16'd0, NULL_HANDLE_RST, ERROR_HANDLE_RST);
    repeat (DEPTH + 2) begin
      send_cmd(ACT_ALLOC, 8'($urandom), 16'($urandom_range(1, 16'hfffe)), {$urandom, $urandom});
      pace_sender();
    end
    wait_idle();
    set_config(16'd63, NULL_HANDLE_RST, ERROR_HANDLE_RST);
    send_cmd(ACT_ALLOC, 8'd0, 16'h4242, '0);
    send_cmd(ACT_FREE, 8'd63, 16'h0000, '0);
    send_cmd(ACT_ALLOC, 8'd0, 16'h4343, '0);
    send_cmd(ACT_ALLOC, 8'd0, 16'h4444, '0);
    wait_idle();
  endtask

  task automatic test_random_phase(input int n_items, input logic [CFG_DATA_W-1:0] first_v,
                                   input logic [CFG_DATA_W-1:0] null_v,
                                   input logic [CFG_DATA_W-1:0] err_v);
    int                  pick;
    int                  hsel;
    logic [2:0]          act;
    logic [7:0]          idx;
    logic [HANDLE_W-1:0] h;
    set_config(first_v, null_v, err_v);
    for (int k = 0; k < n_items; k++) begin
      pick = $urandom_range(0, 99);
      hsel = $urandom_range(0, 19);
      idx = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(DEPTH, 255))
                                         : 8'($urandom_range(0, DEPTH - 1));
      // a small handle pool makes displaced and repeated handles common
      if (hsel < 2) h = cfg_null;
      else if (hsel < 4) h = cfg_error;
      else if (hsel < 12) h = 16'h0100 + 16'($urandom_range(0, 15));
      else h = 16'($urandom);
      if (pick < 27) act = ACT_ALLOC;
      else if (pick < 42) act = ACT_BIND;
      else if (pick < 64) act = ACT_FREE;
      else if (pick < 80) act = ACT_LOOKUP;
      else if (pick < 95) act = ACT_SET_OFF;
      else act = 3'($urandom_range(ACT_BAD_FIRST, ACT_BAD_LAST));
      if (act == ACT_BIND && idx < DEPTH && $urandom_range(0, 4) == 0)
        h = mirror_handle[idx[RIDX_W-1:0]];
      send_cmd(act, idx, h, {$urandom, $urandom});
      pace_sender();
    end
    wait_idle();
  endtask

  initial begin
    cfg_first = FIRST_ALLOC_RST;
    cfg_null = NULL_HANDLE_RST;
    cfg_error = ERROR_HANDLE_RST;
    for (int i = 0; i < DEPTH; i++) begin
      mirror_handle[i] = NULL_HANDLE_RST;
      mirror_offset[i] = '0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_table_full();
    test_random_phase(260, 16'(FIRST_ALLOC_RST), NULL_HANDLE_RST, ERROR_HANDLE_RST);
    test_random_phase(260, 16'd0, 16'h0000, 16'hffff);
    // old null code left in the table now counts as a live handle
    test_random_phase(260, 16'd63, 16'hffff, 16'h0000);
    test_random_phase(260, 16'($urandom), 16'($urandom), 16'($urandom));
    test_random_phase(260, 16'hffe0, 16'h0000, 16'hffff);
    wait_idle();
    // a word that never came back is a failure too
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
